// ===== rtl/ssca_pkg.sv =====
package ssca_pkg;

    localparam int NUM_FRAMES  = 16;
    localparam int FRAME_W     = 4;
    localparam int CNT_W       = 5;
    localparam int BLK_W       = 8;
    localparam int BLKS        = 256;
    localparam int CLASS_W     = 3;
    localparam int NUM_CLASSES = 8;
    localparam int MAX_CLASS   = 7;
    localparam int LINK_W      = BLK_W + 1;
    localparam int MEM_AW      = FRAME_W + BLK_W;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FRAMES = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_READ,
        S_UPDATE,
        S_OUT
    } t_state;

    function automatic logic [3:0] size_class(input logic [11:0] len);
        logic [3:0] c;
        c = 4'd8;
        if (len <= 12'd16) c = 4'd0;
        else if (len <= 12'd32) c = 4'd1;
        else if (len <= 12'd64) c = 4'd2;
        else if (len <= 12'd128) c = 4'd3;
        else if (len <= 12'd256) c = 4'd4;
        else if (len <= 12'd512) c = 4'd5;
        else if (len <= 12'd1024) c = 4'd6;
        else if (len <= 12'd2048) c = 4'd7;
        return c;
    endfunction

endpackage

// ===== rtl/ssca_link_ram.sv =====
module ssca_link_ram (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [ssca_pkg::MEM_AW-1:0]     i_waddr,
    input  logic [ssca_pkg::LINK_W-1:0]     i_wdata,
    input  logic [ssca_pkg::MEM_AW-1:0]     i_raddr,
    output logic [ssca_pkg::LINK_W-1:0]     o_rdata
);

    logic [ssca_pkg::LINK_W-1:0] r_mem [ssca_pkg::NUM_FRAMES*ssca_pkg::BLKS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/slab_size_class_allocator.sv =====
// An allocate goes S_IDLE, S_BUILD (new frame only), S_READ, S_UPDATE, S_OUT; free and
// rejected ones go S_IDLE, S_OUT. S_BUILD writes one link per block (256 >> class blocks).
// One request at a time; the next is accepted the cycle after the result is taken.
// Reset (synchronous, active low): class lists empty, no frames claimed;
// link RAM is not cleared.
module slab_size_class_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // operation[0], request_length[12:1], free_address[28:13]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // block_address[15:0], status[17:16]
);

    localparam int FW = ssca_pkg::FRAME_W;
    localparam int BW = ssca_pkg::BLK_W;
    localparam int LW = ssca_pkg::LINK_W;
    localparam int CW = ssca_pkg::CNT_W;

    ssca_pkg::t_state r_state, n_state;

    logic [FW:0]   r_head  [ssca_pkg::NUM_CLASSES];
    logic [FW:0]   r_fnext [ssca_pkg::NUM_FRAMES];
    logic [LW-1:0] r_ffree [ssca_pkg::NUM_FRAMES];
    logic [2:0]    r_fcls  [ssca_pkg::NUM_FRAMES];
    logic [CW-1:0] r_claimed;

    logic [2:0]    r_cls;
    logic [FW-1:0] r_frm;
    logic [BW-1:0] r_blk;
    logic [15:0]   r_addr;
    logic [1:0]    r_status;

    logic                      ram_we;
    logic [ssca_pkg::MEM_AW-1:0] ram_waddr, ram_raddr;
    logic [LW-1:0]             ram_wdata, ram_rdata;

    logic        in_op;
    logic [11:0] in_len;
    logic [15:0] in_faddr;
    logic [3:0]  in_cls;
    logic [FW-1:0] in_frm;
    logic [BW-1:0] in_blk, blk_mask, b_step, b_next;
    logic [8:0]  b_sum;

    assign in_op    = s_axis_tdata[0];
    assign in_len   = s_axis_tdata[12:1];
    assign in_faddr = s_axis_tdata[28:13];
    assign in_cls   = ssca_pkg::size_class(in_len);
    assign in_frm   = in_faddr[15:12];
    assign blk_mask = ~((BW'(1) << r_fcls[in_frm]) - BW'(1));
    assign in_blk   = in_faddr[11:4] & blk_mask;
    assign b_step   = BW'(1) << r_cls;
    assign b_sum    = {1'b0, r_blk} + {1'b0, b_step};
    assign b_next   = b_sum[BW-1:0];

    assign s_axis_tready = (r_state == ssca_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == ssca_pkg::S_OUT);
    assign m_axis_tdata  = {6'd0, r_status, r_addr};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssca_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (in_op == ssca_pkg::OP_FREE) n_state = ssca_pkg::S_OUT;
                    else if (in_cls > 4'(ssca_pkg::MAX_CLASS)) n_state = ssca_pkg::S_OUT;
                    else if (r_head[in_cls[2:0]][FW]) n_state = ssca_pkg::S_READ;
                    else if (r_claimed < CW'(ssca_pkg::NUM_FRAMES))
                        n_state = ssca_pkg::S_BUILD;
                    else n_state = ssca_pkg::S_OUT;
                end
            end
            ssca_pkg::S_BUILD:  if (b_sum[BW]) n_state = ssca_pkg::S_READ;
            ssca_pkg::S_READ:   n_state = ssca_pkg::S_UPDATE;
            ssca_pkg::S_UPDATE: n_state = ssca_pkg::S_OUT;
            ssca_pkg::S_OUT:    if (m_axis_tready) n_state = ssca_pkg::S_IDLE;
            default:            n_state = ssca_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_frm, r_blk};
        ram_wdata = '0;
        ram_raddr = {r_frm, r_ffree[r_frm][BW-1:0]};
        case (r_state)
            ssca_pkg::S_IDLE: begin
                ram_waddr = {in_frm, in_blk};
                ram_wdata = r_ffree[in_frm];
                ram_we    = s_axis_tvalid && (in_op == ssca_pkg::OP_FREE) &&
                            ({1'b0, in_frm} < r_claimed);
            end
            ssca_pkg::S_BUILD: begin
                ram_we    = 1'b1;
                ram_wdata = b_sum[BW] ? '0 : {1'b1, b_next};
            end
            default: ram_we = 1'b0;
        endcase
    end

    ssca_link_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ssca_pkg::S_IDLE;
            r_claimed <= '0;
            for (int i = 0; i < ssca_pkg::NUM_CLASSES; i++) r_head[i] <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ssca_pkg::S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cls    <= in_cls[2:0];
                        r_addr   <= '0;
                        r_status <= ssca_pkg::ST_OK;
                        r_blk    <= '0;
                        if (in_op == ssca_pkg::OP_FREE) begin
                            if ({1'b0, in_frm} >= r_claimed) begin
                                r_status <= ssca_pkg::ST_BAD_FREE;
                            end else begin
                                if (!r_ffree[in_frm][BW]) begin
                                    r_fnext[in_frm] <= r_head[r_fcls[in_frm]];
                                    r_head[r_fcls[in_frm]] <= {1'b1, in_frm};
                                end
                                r_ffree[in_frm] <= {1'b1, in_blk};
                            end
                        end else if (in_cls > 4'(ssca_pkg::MAX_CLASS)) begin
                            r_status <= ssca_pkg::ST_TOO_LARGE;
                        end else if (r_head[in_cls[2:0]][FW]) begin
                            r_frm <= r_head[in_cls[2:0]][FW-1:0];
                        end else if (r_claimed < CW'(ssca_pkg::NUM_FRAMES)) begin
                            r_frm <= r_claimed[FW-1:0];
                            r_claimed <= r_claimed + CW'(1);
                            r_fcls[r_claimed[FW-1:0]]  <= in_cls[2:0];
                            r_ffree[r_claimed[FW-1:0]] <= {1'b1, BW'(0)};
                            r_fnext[r_claimed[FW-1:0]] <= '0;
                            r_head[in_cls[2:0]] <= {1'b1, r_claimed[FW-1:0]};
                        end else begin
                            r_status <= ssca_pkg::ST_NO_FRAMES;
                        end
                    end
                end
                ssca_pkg::S_BUILD: r_blk <= b_next;
                ssca_pkg::S_UPDATE: begin
                    r_ffree[r_frm] <= ram_rdata;
                    if (!ram_rdata[BW]) begin
                        r_head[r_cls] <= r_fnext[r_frm][FW] ? r_fnext[r_frm] : '0;
                    end
                    r_addr <= {r_frm, r_ffree[r_frm][BW-1:0], 4'd0};
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== test/slab_size_class_allocator_tb.sv =====
`timescale 1ns / 1ps

module slab_size_class_allocator_tb;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } t_alloc_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    slab_size_class_allocator dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [4:0]  pool_class_head [ssca_pkg::NUM_CLASSES];
    logic [4:0]  pool_frame_next [ssca_pkg::NUM_FRAMES];
    logic [8:0]  pool_free_head [ssca_pkg::NUM_FRAMES];
    logic [2:0]  pool_frame_class [ssca_pkg::NUM_FRAMES];
    logic [8:0]  pool_link [ssca_pkg::NUM_FRAMES*ssca_pkg::BLKS];
    int          pool_claimed;

    t_alloc_result expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int cycles = 0;
    int hold_off = 0;
    bit stall_enable = 1'b1;
    int status_count[4];
    // addresses of allocated blocks
    logic [15:0] live_blocks[$];

    function automatic int class_of(input logic [11:0] len);
        int c;
        c = 0;
        while (c < 8 && (16 << c) < len) c++;
        return c;
    endfunction

    function automatic t_alloc_result predict_request(input logic op,
            input logic [11:0] len, input logic [15:0] faddr);
        t_alloc_result r;
        int c, f, b, step;
        logic [8:0] nxt;
        r = '0;
        if (op == ssca_pkg::OP_ALLOC) begin
            c = class_of(len);
            if (c > ssca_pkg::MAX_CLASS) begin
                r.status = ssca_pkg::ST_TOO_LARGE;
            end else begin
                if (!pool_class_head[c][4] && pool_claimed < ssca_pkg::NUM_FRAMES) begin
                    step = 1 << c;
                    for (b = 0; b < ssca_pkg::BLKS; b += step)
                        pool_link[pool_claimed*ssca_pkg::BLKS + b] =
                            (b + step < ssca_pkg::BLKS) ? {1'b1, 8'(b + step)} : 9'd0;
                    pool_free_head[pool_claimed] = 9'h100;
                    pool_frame_class[pool_claimed] = 3'(c);
                    pool_frame_next[pool_claimed] = 5'd0;
                    pool_class_head[c] = {1'b1, 4'(pool_claimed)};
                    pool_claimed++;
                end
                if (!pool_class_head[c][4]) begin
                    r.status = ssca_pkg::ST_NO_FRAMES;
                end else begin
                    f = pool_class_head[c][3:0];
                    b = pool_free_head[f][7:0];
                    nxt = pool_link[f*ssca_pkg::BLKS + b];
                    pool_free_head[f] = nxt;
                    if (!nxt[8])
                        pool_class_head[c] = pool_frame_next[f][4] ? pool_frame_next[f] : 5'd0;
                    r.addr = 16'(f*4096 + b*16);
                    r.status = ssca_pkg::ST_OK;
                end
            end
        end else begin
            f = faddr[15:12];
            if (f >= pool_claimed) begin
                r.status = ssca_pkg::ST_BAD_FREE;
            end else begin
                c = pool_frame_class[f];
                b = faddr[11:4] & ~((1 << c) - 1);
                if (!pool_free_head[f][8]) begin
                    pool_frame_next[f] = pool_class_head[c];
                    pool_class_head[c] = {1'b1, 4'(f)};
                end
                pool_link[f*ssca_pkg::BLKS + b] = pool_free_head[f];
                pool_free_head[f] = {1'b1, 8'(b)};
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
                 results_seen);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // receiver: own stall pattern plus long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_enable) begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[15:0] !== want.addr)
                    report_mismatch("block_address", m_axis_tdata[15:0], want.addr);
                if (m_axis_tdata[17:16] !== want.status)
                    report_mismatch("status", m_axis_tdata[17:16], want.status);
                status_count[want.status]++;
            end
        end
    end

    task automatic send_request(input logic op, input logic [11:0] len,
            input logic [15:0] faddr);
        t_alloc_result r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b0, faddr, len, op};
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_request(op, len, faddr);
        expected_results.push_back(r);
        if (op == ssca_pkg::OP_ALLOC && r.status == ssca_pkg::ST_OK)
            live_blocks.push_back(r.addr);
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (n > 0) s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic free_random_live();
        int k;
        logic [15:0] a;
        k = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[k] | 16'($urandom_range(0, 15));
        live_blocks.delete(k);
        send_request(ssca_pkg::OP_FREE, 12'($urandom), a);
    endtask

    task automatic test_directed();
        send_request(ssca_pkg::OP_FREE, 12'd0, 16'h0000);
        send_request(ssca_pkg::OP_ALLOC, 12'd0, 16'hffff);
        send_request(ssca_pkg::OP_ALLOC, 12'd8, 16'h0);
        send_request(ssca_pkg::OP_ALLOC, 12'd9, 16'h0);
        send_request(ssca_pkg::OP_ALLOC, 12'd16, 16'h0);
        send_request(ssca_pkg::OP_ALLOC, 12'd17, 16'h0);
        send_request(ssca_pkg::OP_ALLOC, 12'd2048, 16'h0);
        send_request(ssca_pkg::OP_ALLOC, 12'd2049, 16'h0);
        send_request(ssca_pkg::OP_ALLOC, 12'd4095, 16'h0);
        send_request(ssca_pkg::OP_ALLOC, 12'd2048, 16'h0);
        send_request(ssca_pkg::OP_ALLOC, 12'd2000, 16'h0);
        send_request(ssca_pkg::OP_FREE, 12'hfff, 16'h080f);
        send_request(ssca_pkg::OP_FREE, 12'd0, 16'h0807);
        send_request(ssca_pkg::OP_ALLOC, 12'd1500, 16'h0);
        send_request(ssca_pkg::OP_ALLOC, 12'd1500, 16'h0);
        send_request(ssca_pkg::OP_FREE, 12'd0, 16'hffff);
        send_request(ssca_pkg::OP_FREE, 12'd0, 16'h0013);
        send_request(ssca_pkg::OP_ALLOC, 12'd1, 16'h0);
        drain();
    endtask

    task automatic test_random(input int count);
        int i, burst;
        i = 0;
        while (i < count) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                case ($urandom_range(0, 9))
                    0: send_request(ssca_pkg::OP_FREE, 12'($urandom), 16'($urandom));
                    1: send_request(ssca_pkg::OP_ALLOC, 12'($urandom), 16'($urandom));
                    2, 3, 4: begin
                        if (live_blocks.size() != 0) free_random_live();
                        else send_request(ssca_pkg::OP_ALLOC, 12'($urandom_range(0, 64)),
                                          16'($urandom));
                    end
                    default: send_request(ssca_pkg::OP_ALLOC,
                        ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2048))
                                                    : 12'($urandom_range(0, 96)),
                        16'($urandom));
                endcase
                i++;
            end
            random_gap();
        end
    endtask

    task automatic test_backpressure();
        hold_off <= 300;
        repeat (20) send_request(ssca_pkg::OP_ALLOC, 12'($urandom_range(0, 48)),
                                 16'($urandom));
        drain();
    endtask

    task automatic test_full_speed();
        stall_enable = 1'b0;
        repeat (60) begin
            if (live_blocks.size() != 0 && $urandom_range(0, 1)) free_random_live();
            else send_request(ssca_pkg::OP_ALLOC, 12'($urandom_range(0, 32)),
                              16'($urandom));
        end
        drain();
        stall_enable = 1'b1;
    endtask

    initial begin
        int k;
        for (k = 0; k < ssca_pkg::NUM_CLASSES; k++) pool_class_head[k] = '0;
        pool_claimed = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(700);
        drain();
        test_full_speed();
        drain();
        $display("covered %0d results: ok %0d, out of frames %0d, too large %0d, bad free %0d",
                 results_seen, status_count[ssca_pkg::ST_OK],
                 status_count[ssca_pkg::ST_NO_FRAMES], status_count[ssca_pkg::ST_TOO_LARGE],
                 status_count[ssca_pkg::ST_BAD_FREE]);
        $display("frames claimed %0d, long receiver hold-off and full-rate phases run",
                 pool_claimed);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ssca_pkg.sv
rtl/ssca_link_ram.sv
rtl/slab_size_class_allocator.sv
test/slab_size_class_allocator_tb.sv
